### rtl/spi_interrupt_transfer_engine_top_macros.svh
// ---------------------------------------------------------------------------
// SPI transfer engine assertion macros
// Immediate-cycle and next-cycle property checks; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef SPI_INTERRUPT_TRANSFER_ENGINE_TOP_MACROS_SVH
`define SPI_INTERRUPT_TRANSFER_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SITE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("site: same-cycle check failed");
`define SITE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("site: next-cycle check failed");
`else
`define SITE_ASSERT_NOW(label, ante, cons)
`define SITE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/site_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SPI transfer engine package
// Item types, codes and constants shared by the engine modules.
// ---------------------------------------------------------------------------
package site_pkg;

    localparam int LENGTH_BITS_DEFAULT = 16;
    localparam int WORD_BITS           = 16;
    localparam int CFG_INDEX_BITS      = 2;
    localparam int CFG_DATA_BITS       = 1;

    localparam logic [WORD_BITS-1:0] MASK_8BIT  = 16'h00FF;
    localparam logic [WORD_BITS-1:0] MASK_16BIT = 16'hFFFF;

    // event_mask bit positions
    localparam int EV_TX_DONE    = 0;
    localparam int EV_RX_DONE    = 1;
    localparam int EV_OVERRUN    = 2;
    localparam int EV_MODE_FAULT = 3;
    localparam int EV_CRC_ERROR  = 4;

    typedef enum logic [1:0] {
        KIND_VISIT = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_XFER  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_BUSY       = 3'd1,
        STATUS_ODD_LENGTH = 3'd2,
        STATUS_NO_BUFFER  = 3'd3,
        STATUS_DISABLED   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MODE_TX_ONLY = 2'd0,
        MODE_RX_ONLY = 2'd1,
        MODE_TX_RX   = 2'd2
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FRAME_16BIT      = 2'd0,
        CFG_ERROR_IRQ_ENABLE = 2'd1,
        CFG_PORT_ENABLED     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        kind_t                kind;
        logic [WORD_BITS-1:0] length_bytes;
        logic                 has_tx_buffer;
        logic                 has_rx_buffer;
        logic                 flag_tx_empty;
        logic                 flag_rx_full;
        logic                 flag_overrun;
        logic                 flag_mode_fault;
        logic                 flag_crc_error;
        logic [WORD_BITS-1:0] rx_word;
        logic [WORD_BITS-1:0] tx_word;
    } req_t;

    typedef struct packed {
        logic [2:0]           start_status;
        logic                 dr_write_valid;
        logic [WORD_BITS-1:0] dr_write_word;
        logic                 dr_read;
        logic                 rx_store_valid;
        logic [WORD_BITS-1:0] rx_store_word;
        logic [4:0]           event_mask;
        logic [1:0]           irq_enable_mask;
        logic                 crc_flag_clear;
    } rsp_t;

endpackage

### rtl/site_in_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SPI transfer engine input stage
// Holds one accepted item until the sequencer takes it.
// ---------------------------------------------------------------------------
module site_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  site_pkg::req_t    req_item,
    output logic              req_stall,
    input  logic              advance,
    output logic              held_valid,
    output site_pkg::req_t    held_item
);

    logic           held_valid_reg;
    logic           held_valid_next;
    site_pkg::req_t held_item_reg;
    logic           load;

    // full stage frees up in the same cycle it hands its item on
    assign req_stall = held_valid_reg && !advance;
    assign load      = req_valid && !req_stall;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        if (load)
        begin
            held_valid_next = 1'b1;
        end
        else if (advance)
        begin
            held_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_item_reg <= req_item;
        end
    end

    assign held_valid = held_valid_reg;
    assign held_item  = held_item_reg;

endmodule

### rtl/site_seq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SPI transfer engine sequencer
// Configuration, transfer state and the per-item start/visit logic.
// ---------------------------------------------------------------------------
`include "spi_interrupt_transfer_engine_top_macros.svh"

module site_seq #(
    parameter int LENGTH_BITS = site_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [site_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [site_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                fire,
    input  site_pkg::req_t                      item,
    output site_pkg::rsp_t                      result
);

    typedef logic [LENGTH_BITS-1:0] count_t;

    // configuration
    logic frame16_reg;
    logic err_irq_reg;
    logic port_en_reg;

    // transfer state
    count_t                tx_rem_reg,  tx_rem_next;
    count_t                rx_rem_reg,  rx_rem_next;
    logic                  tx_busy_reg, tx_busy_next;
    logic                  rx_busy_reg, rx_busy_next;
    site_pkg::mode_t       mode_reg,    mode_next;
    logic                  rx_tgt_reg,  rx_tgt_next;
    logic                  tx_irq_reg,  tx_irq_next;
    logic                  rx_irq_reg,  rx_irq_next;

    count_t                          len;
    count_t                          step;
    logic                            odd;
    logic [site_pkg::WORD_BITS-1:0]  fmask;
    site_pkg::status_t               status;
    logic [4:0]                      ev;

    assign len   = LENGTH_BITS'(item.length_bytes);
    assign step  = {{(LENGTH_BITS-2){1'b0}}, frame16_reg, !frame16_reg};
    assign odd   = frame16_reg && len[0];
    assign fmask = frame16_reg ? site_pkg::MASK_16BIT : site_pkg::MASK_8BIT;

    always_comb
    begin
        tx_rem_next  = tx_rem_reg;
        rx_rem_next  = rx_rem_reg;
        tx_busy_next = tx_busy_reg;
        rx_busy_next = rx_busy_reg;
        mode_next    = mode_reg;
        rx_tgt_next  = rx_tgt_reg;
        tx_irq_next  = tx_irq_reg;
        rx_irq_next  = rx_irq_reg;
        status       = site_pkg::STATUS_OK;
        ev           = '0;
        result       = '0;

        if (fire)
        begin
            unique case (item.kind)
                site_pkg::KIND_WRITE:
                begin
                    if (!item.has_tx_buffer)
                        status = site_pkg::STATUS_NO_BUFFER;
                    else if (!port_en_reg)
                        status = site_pkg::STATUS_DISABLED;
                    else if (len == '0)
                        status = site_pkg::STATUS_OK;
                    else if (tx_busy_reg)
                        status = site_pkg::STATUS_BUSY;
                    else if (odd)
                        status = site_pkg::STATUS_ODD_LENGTH;
                    else
                    begin
                        tx_rem_next  = len;
                        tx_busy_next = 1'b1;
                        mode_next    = site_pkg::MODE_TX_ONLY;
                        tx_irq_next  = 1'b1;
                    end
                end
                site_pkg::KIND_READ:
                begin
                    // arms the receive side only
                    if (!item.has_rx_buffer)
                        status = site_pkg::STATUS_NO_BUFFER;
                    else if (!port_en_reg)
                        status = site_pkg::STATUS_DISABLED;
                    else if (len == '0)
                        status = site_pkg::STATUS_OK;
                    else if (rx_busy_reg)
                        status = site_pkg::STATUS_BUSY;
                    else if (odd)
                        status = site_pkg::STATUS_ODD_LENGTH;
                    else
                    begin
                        rx_rem_next  = len;
                        rx_busy_next = 1'b1;
                        rx_tgt_next  = 1'b1;
                        mode_next    = site_pkg::MODE_RX_ONLY;
                        rx_irq_next  = 1'b1;
                    end
                end
                site_pkg::KIND_XFER:
                begin
                    if (!port_en_reg)
                        status = site_pkg::STATUS_DISABLED;
                    else if (len == '0)
                        status = site_pkg::STATUS_OK;
                    else if (tx_busy_reg || rx_busy_reg)
                        status = site_pkg::STATUS_BUSY;
                    else if (odd)
                        status = site_pkg::STATUS_ODD_LENGTH;
                    else if (!item.has_tx_buffer && !item.has_rx_buffer)
                        status = site_pkg::STATUS_NO_BUFFER;
                    else
                    begin
                        tx_rem_next  = len;
                        tx_busy_next = 1'b1;
                        tx_irq_next  = 1'b1;
                        rx_rem_next  = item.has_rx_buffer ? len : '0;
                        rx_busy_next = item.has_rx_buffer;
                        rx_tgt_next  = item.has_rx_buffer;
                        rx_irq_next  = item.has_rx_buffer;
                        if (!item.has_rx_buffer)
                            mode_next = site_pkg::MODE_TX_ONLY;
                        else if (item.has_tx_buffer)
                            mode_next = site_pkg::MODE_TX_RX;
                        else
                            mode_next = site_pkg::MODE_RX_ONLY;
                    end
                end
                default:
                begin
                    // interrupt visit: feed TX, drain RX, then errors
                    if (item.flag_tx_empty && tx_irq_reg)
                    begin
                        if (tx_rem_reg != '0)
                        begin
                            result.dr_write_valid = 1'b1;
                            result.dr_write_word  = (mode_reg == site_pkg::MODE_RX_ONLY) ?
                                                    fmask : (item.tx_word & fmask);
                            tx_rem_next = (tx_rem_reg > step) ? (tx_rem_reg - step) : '0;
                        end
                        else
                        begin
                            tx_busy_next = 1'b0;
                            tx_irq_next  = 1'b0;
                            ev[site_pkg::EV_TX_DONE] = (mode_reg == site_pkg::MODE_TX_ONLY);
                        end
                    end
                    if (item.flag_rx_full && rx_irq_reg)
                    begin
                        if (rx_rem_reg != '0)
                        begin
                            result.dr_read = 1'b1;
                            if (rx_tgt_reg)
                            begin
                                result.rx_store_valid = 1'b1;
                                result.rx_store_word  = item.rx_word & fmask;
                            end
                            rx_rem_next = (rx_rem_reg > step) ? (rx_rem_reg - step) : '0;
                        end
                        else
                        begin
                            rx_busy_next = 1'b0;
                            rx_irq_next  = 1'b0;
                            ev[site_pkg::EV_RX_DONE] = (mode_reg == site_pkg::MODE_TX_RX) ||
                                                       (mode_reg == site_pkg::MODE_RX_ONLY);
                        end
                    end
                    if (err_irq_reg)
                    begin
                        if (item.flag_overrun)
                        begin
                            result.dr_read = 1'b1;
                            ev[site_pkg::EV_OVERRUN] = 1'b1;
                        end
                        ev[site_pkg::EV_MODE_FAULT] = item.flag_mode_fault;
                        if (item.flag_crc_error)
                        begin
                            result.crc_flag_clear = 1'b1;
                            ev[site_pkg::EV_CRC_ERROR] = 1'b1;
                        end
                    end
                end
            endcase
        end

        result.start_status    = status;
        result.event_mask      = ev;
        result.irq_enable_mask = {rx_irq_next, tx_irq_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame16_reg <= 1'b0;
            err_irq_reg <= 1'b0;
            port_en_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (site_pkg::cfg_index_t'(cfg_index))
                site_pkg::CFG_FRAME_16BIT:      frame16_reg <= cfg_data[0];
                site_pkg::CFG_ERROR_IRQ_ENABLE: err_irq_reg <= cfg_data[0];
                site_pkg::CFG_PORT_ENABLED:     port_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_rem_reg  <= '0;
            rx_rem_reg  <= '0;
            tx_busy_reg <= 1'b0;
            rx_busy_reg <= 1'b0;
            mode_reg    <= site_pkg::MODE_TX_ONLY;
            rx_tgt_reg  <= 1'b0;
            tx_irq_reg  <= 1'b0;
            rx_irq_reg  <= 1'b0;
        end
        else
        begin
            tx_rem_reg  <= tx_rem_next;
            rx_rem_reg  <= rx_rem_next;
            tx_busy_reg <= tx_busy_next;
            rx_busy_reg <= rx_busy_next;
            mode_reg    <= mode_next;
            rx_tgt_reg  <= rx_tgt_next;
            tx_irq_reg  <= tx_irq_next;
            rx_irq_reg  <= rx_irq_next;
        end
    end

    // busy marks and interrupt enables are always set and cleared together
    `SITE_ASSERT_NOW(a_tx_irq_tracks_busy, 1'b1, tx_irq_reg == tx_busy_reg)
    `SITE_ASSERT_NOW(a_rx_irq_tracks_busy, 1'b1, rx_irq_reg == rx_busy_reg)
    `SITE_ASSERT_NOW(a_store_needs_read, result.rx_store_valid, result.dr_read)
    `SITE_ASSERT_NEXT(a_tx_count_down,
        fire && (item.kind == site_pkg::KIND_VISIT) && item.flag_tx_empty &&
        tx_irq_reg && (tx_rem_reg != '0),
        tx_rem_reg < $past(tx_rem_reg))

endmodule

### rtl/site_out_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SPI transfer engine output stage
// Result register holding one item until the receiver takes it.
// ---------------------------------------------------------------------------
module site_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  site_pkg::rsp_t    result,
    output logic              ready,
    output logic              rsp_valid,
    output site_pkg::rsp_t    rsp_item,
    input  logic              rsp_stall
);

    logic           rsp_valid_reg;
    logic           rsp_valid_next;
    site_pkg::rsp_t rsp_item_reg;

    // empty, or emptying this cycle
    assign ready = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_item_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

### rtl/spi_interrupt_transfer_engine_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SPI interrupt transfer engine
// Start requests and interrupt visits in, one result item out per item.
// ---------------------------------------------------------------------------
// Usage:
//   req_valid / req_stall / req_item carry one item: a start request
//   (write, read, full-duplex) or one interrupt visit with status flags and
//   data words. rsp_valid / rsp_stall / rsp_item return exactly one result
//   item per input item, in order.
//   cfg_write / cfg_index / cfg_data set frame size, error interrupt enable
//   and port enable; write them only while no item is in flight.
// Timing:
//   An accepted item waits in the input register, is evaluated out of it,
//   and its result is registered in the result register once that is free;
//   rsp_valid rises from there. Evaluation is a single pass of short logic,
//   so one item per cycle is sustained with no stall on either side.
// Stall:
//   If rsp_stall holds a result, the next item is still evaluated only when
//   the result register frees up; the input register then fills and
//   req_stall rises. Nothing is dropped.
// Reset:
//   rst_n clears counters, busy marks, mode, enables and all valid flags.
// ---------------------------------------------------------------------------
`include "spi_interrupt_transfer_engine_top_macros.svh"

module spi_interrupt_transfer_engine_top #(
    parameter int LENGTH_BITS = site_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  site_pkg::req_t                      req_item,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output site_pkg::rsp_t                      rsp_item,
    input  logic                                cfg_write,
    input  logic [site_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [site_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    logic           held_valid;
    site_pkg::req_t held_item;
    logic           out_ready;
    logic           advance;
    site_pkg::rsp_t result;

    // an item moves from input register to result register when both allow
    assign advance = held_valid && out_ready;

    site_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_item   (req_item),
        .req_stall  (req_stall),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    site_seq #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (advance),
        .item      (held_item),
        .result    (result)
    );

    site_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .result    (result),
        .ready     (out_ready),
        .rsp_valid (rsp_valid),
        .rsp_item  (rsp_item),
        .rsp_stall (rsp_stall)
    );

    // input only backs up when the result register is held by the receiver
    `SITE_ASSERT_NOW(a_stall_only_when_blocked, req_stall, held_valid && rsp_valid && rsp_stall)
    // every evaluated item shows up as a result on the next cycle
    `SITE_ASSERT_NEXT(a_advance_gives_result, advance, rsp_valid)

endmodule
